>>> hw/rtl/hvd_pkg.sv
// Shared types, constants and tables of the haversine distance pipeline.
`timescale 1ns / 1ps
`default_nettype none

package hvd_pkg;

  // Default parameter values.
  localparam int TRIG_ITER_DEF  = 24;
  localparam int ANGLE_FRAC_DEF = 22;

  // Field widths.
  localparam int LAT_W      = 30;
  localparam int LON_W      = 31;
  localparam int DIST_W     = 32;
  localparam int RAD_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CORE_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CORE_LON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6371;

  // Internal number formats: angles and trig values in unsigned Q30.
  localparam int ANG_W = 31;
  localparam int Q30_W = 31;
  localparam int XY_W  = 34;
  localparam int Z_W   = 33;

  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [XY_W-1:0] INV_GAIN = 34'sd652032875;
  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

  // Square root: one root bit per stage, root of a Q60 value.
  localparam int SQRT_STEPS = 31;
  localparam int REM_W      = 62;

  typedef logic [ANG_W-1:0] ang_t;
  typedef logic [Q30_W-1:0] q30_t;

  // Angles for the four trig lanes.
  typedef struct packed {
    ang_t dlat_h;
    ang_t dlon_h;
    ang_t clat;
    ang_t tlat;
  } ang4_t;

  // Clamped trig results.
  typedef struct packed {
    q30_t s1;
    q30_t s2;
    q30_t c1;
    q30_t c2;
  } trig4_t;

  // Haversine value and its complement.
  typedef struct packed {
    q30_t f;
    q30_t g;
    logic zero;
  } hav_t;

  // Square roots that feed the arc tangent.
  typedef struct packed {
    q30_t sq;
    q30_t cq;
    logic zero;
  } root_t;

  // Arc tangent of 2^-k in Q30 radians.
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] k);
    logic signed [Z_W-1:0] a;
    case (k)
      5'd0:  a = 33'sd843314856;
      5'd1:  a = 33'sd497837829;
      5'd2:  a = 33'sd263043836;
      5'd3:  a = 33'sd133525158;
      5'd4:  a = 33'sd67021686;
      5'd5:  a = 33'sd33543515;
      5'd6:  a = 33'sd16775850;
      5'd7:  a = 33'sd8388437;
      5'd8:  a = 33'sd4194282;
      5'd9:  a = 33'sd2097149;
      5'd10: a = 33'sd1048575;
      5'd11: a = 33'sd524287;
      5'd12: a = 33'sd262143;
      5'd13: a = 33'sd131071;
      5'd14: a = 33'sd65535;
      5'd15: a = 33'sd32767;
      5'd16: a = 33'sd16383;
      5'd17: a = 33'sd8191;
      5'd18: a = 33'sd4095;
      5'd19: a = 33'sd2047;
      5'd20: a = 33'sd1023;
      5'd21: a = 33'sd511;
      5'd22: a = 33'sd255;
      5'd23: a = 33'sd127;
      5'd24: a = 33'sd63;
      5'd25: a = 33'sd31;
      5'd26: a = 33'sd15;
      5'd27: a = 33'sd7;
      5'd28: a = 33'sd3;
      5'd29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hvd_in_if.sv
// Target point channel.
`timescale 1ns / 1ps
`default_nettype none

interface hvd_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [hvd_pkg::LAT_W-1:0] target_lat;
  logic signed [hvd_pkg::LON_W-1:0] target_lon;

  modport source (output valid, output target_lat, output target_lon, input ready);
  modport sink (input valid, input target_lat, input target_lon, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hvd_out_if.sv
// Distance result channel.
`timescale 1ns / 1ps
`default_nettype none

interface hvd_out_if;
  logic                        valid;
  logic                        ready;
  logic [hvd_pkg::DIST_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hvd_cfg_if.sv
// Configuration write channel.
`timescale 1ns / 1ps
`default_nettype none

interface hvd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hvd_pkg::CFG_IDX_W-1:0]  index;
  logic [hvd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hvd_prep.sv
// Angle preparation: saturation, differences and conversion to Q30 radians.
`timescale 1ns / 1ps
`default_nettype none

module hvd_prep #(
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic signed [hvd_pkg::LAT_W-1:0] core_lat,
  input  wire logic signed [hvd_pkg::LON_W-1:0] core_lon,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [hvd_pkg::LAT_W-1:0] in_lat,
  input  wire logic signed [hvd_pkg::LON_W-1:0] in_lon,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output hvd_pkg::ang4_t                       out_data
);

  localparam int N = 3;
  localparam logic signed [33:0] LAT_LIM = 34'sd90 <<< ANGLE_FRAC_BITS;
  localparam logic signed [33:0] LON_LIM = 34'sd180 <<< ANGLE_FRAC_BITS;
  localparam logic signed [33:0] FULL    = 34'sd360 <<< ANGLE_FRAC_BITS;
  localparam int SH_HALF = ANGLE_FRAC_BITS + 3;
  localparam int SH_FULL = ANGLE_FRAC_BITS + 2;
  localparam logic [58:0] RND_HALF = 59'(1) << (SH_HALF - 1);
  localparam logic [58:0] RND_FULL = 59'(1) << (SH_FULL - 1);

  logic [N-1:0] v_r;
  logic         en;

  assign en        = !v_r[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[N-1];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  function automatic logic signed [33:0] sat(input logic signed [33:0] v,
                                             input logic signed [33:0] lim);
    logic signed [33:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

  function automatic logic [31:0] mag(input logic signed [33:0] v);
    logic signed [33:0] a;
    a = (v < 0) ? -v : v;
    return a[31:0];
  endfunction

  // Stage 0: saturate, take differences and magnitudes, wrap the longitude.
  logic signed [33:0] tlat, tlon, clat, clon, dlon_a;
  logic [31:0]        dlat_m, dlon_m, clat_m, tlat_m;

  always_comb begin
    tlat   = sat(34'(in_lat), LAT_LIM);
    tlon   = sat(34'(in_lon), LON_LIM);
    clat   = sat(34'(core_lat), LAT_LIM);
    clon   = sat(34'(core_lon), LON_LIM);
    dlat_m = mag(tlat - clat);
    dlon_a = 34'(mag(tlon - clon));
    if (dlon_a > LON_LIM) dlon_a = FULL - dlon_a;
    dlon_m = dlon_a[31:0];
    clat_m = mag(clat);
    tlat_m = mag(tlat);
  end

  logic [31:0] m_r [4];
  logic [58:0] p_r [4];
  hvd_pkg::ang4_t a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= dlat_m;
      m_r[1] <= dlon_m;
      m_r[2] <= clat_m;
      m_r[3] <= tlat_m;
    end
  end

  // Stage 1: multiply by pi/180 in Q32.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        p_r[l] <= 59'(m_r[l]) * 59'(hvd_pkg::DEG2RAD_Q32);
      end
    end
  end

  // Stage 2: round half up to Q30; half angles take one more bit of shift.
  logic [58:0] r0, r1, r2, r3;
  always_comb begin
    r0 = (p_r[0] + RND_HALF) >> SH_HALF;
    r1 = (p_r[1] + RND_HALF) >> SH_HALF;
    r2 = (p_r[2] + RND_FULL) >> SH_FULL;
    r3 = (p_r[3] + RND_FULL) >> SH_FULL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.dlat_h <= r0[hvd_pkg::ANG_W-1:0];
      a_r.dlon_h <= r1[hvd_pkg::ANG_W-1:0];
      a_r.clat   <= r2[hvd_pkg::ANG_W-1:0];
      a_r.tlat   <= r3[hvd_pkg::ANG_W-1:0];
    end
  end

  assign out_data = a_r;

endmodule

`default_nettype wire

>>> hw/rtl/hvd_rot.sv
// Four-lane pipelined CORDIC in rotation mode for the sines and cosines.
`timescale 1ns / 1ps
`default_nettype none

module hvd_rot #(
  parameter int TRIG_ITERATIONS = hvd_pkg::TRIG_ITER_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire hvd_pkg::ang4_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output hvd_pkg::trig4_t     out_data
);

  localparam int N = TRIG_ITERATIONS + 1;
  localparam int XW = hvd_pkg::XY_W;
  localparam int ZW = hvd_pkg::Z_W;

  logic [N-1:0] v_r;
  logic         en;

  assign en        = !v_r[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  logic signed [XW-1:0] x_r [N][4];
  logic signed [XW-1:0] y_r [N][4];
  logic signed [ZW-1:0] z_r [N][4];
  hvd_pkg::ang_t        ang [4];

  assign ang[0] = in_data.dlat_h;
  assign ang[1] = in_data.dlon_h;
  assign ang[2] = in_data.clat;
  assign ang[3] = in_data.tlat;

  // Load stage: unit vector scaled by the inverse gain.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        x_r[0][l] <= hvd_pkg::INV_GAIN;
        y_r[0][l] <= '0;
        z_r[0][l] <= ZW'(ang[l]);
      end
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    localparam int K = i % 32;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (!z_r[i][l][ZW-1]) begin
            x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> K);
            y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> K);
            z_r[i+1][l] <= z_r[i][l] - hvd_pkg::atan_q30(5'(K));
          end else begin
            x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> K);
            y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> K);
            z_r[i+1][l] <= z_r[i][l] + hvd_pkg::atan_q30(5'(K));
          end
        end
      end
    end
  end

  function automatic hvd_pkg::q30_t clamp_q30(input logic signed [XW-1:0] v);
    hvd_pkg::q30_t r;
    if (v < 0) r = '0;
    else if (v > XW'(hvd_pkg::Q30_ONE)) r = hvd_pkg::Q30_ONE;
    else r = v[hvd_pkg::Q30_W-1:0];
    return r;
  endfunction

  // Sines from the half-difference lanes, cosines from the latitude lanes.
  assign out_data.s1 = clamp_q30(y_r[N-1][0]);
  assign out_data.s2 = clamp_q30(y_r[N-1][1]);
  assign out_data.c1 = clamp_q30(x_r[N-1][2]);
  assign out_data.c2 = clamp_q30(x_r[N-1][3]);

endmodule

`default_nettype wire

>>> hw/rtl/hvd_hav.sv
// Haversine products: f = s1^2 + s2^2 * c1 * c2, and g = 1 - f.
`timescale 1ns / 1ps
`default_nettype none

module hvd_hav (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire hvd_pkg::trig4_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output hvd_pkg::hav_t        out_data
);

  localparam int N  = 4;
  localparam int QW = hvd_pkg::Q30_W;

  logic [N-1:0] v_r;
  logic         en;

  assign en        = !v_r[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  // Q30 product rounded half up back to Q30; operands never exceed one.
  function automatic hvd_pkg::q30_t rnd(input logic [61:0] p);
    logic [61:0] s;
    s = (p + (62'(1) << 29)) >> 30;
    return s[QW-1:0];
  endfunction

  logic [61:0]   p1_r, q_r, m_r, m2_r;
  hvd_pkg::q30_t c1_r, c2_r, c2b_r, p1q_r, p1q2_r;
  hvd_pkg::hav_t h_r;

  // Stage 0: squares of both sines.
  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= 62'(in_data.s1) * 62'(in_data.s1);
      q_r  <= 62'(in_data.s2) * 62'(in_data.s2);
      c1_r <= in_data.c1;
      c2_r <= in_data.c2;
    end
  end

  // Stage 1: times the core cosine.
  always_ff @(posedge clk) begin
    if (en) begin
      p1q_r <= rnd(p1_r);
      m_r   <= 62'(rnd(q_r)) * 62'(c1_r);
      c2b_r <= c2_r;
    end
  end

  // Stage 2: times the target cosine.
  always_ff @(posedge clk) begin
    if (en) begin
      p1q2_r <= p1q_r;
      m2_r   <= 62'(rnd(m_r)) * 62'(c2b_r);
    end
  end

  // Stage 3: sum, clamp to one and complement.
  logic [QW:0]   f_sum;
  hvd_pkg::q30_t f_c;
  always_comb begin
    f_sum = (QW+1)'(p1q2_r) + (QW+1)'(rnd(m2_r));
    f_c   = (f_sum > (QW+1)'(hvd_pkg::Q30_ONE)) ? hvd_pkg::Q30_ONE : f_sum[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_r.f    <= f_c;
      h_r.g    <= hvd_pkg::Q30_ONE - f_c;
      h_r.zero <= (f_c == '0);
    end
  end

  assign out_data = h_r;

endmodule

`default_nettype wire

>>> hw/rtl/hvd_isqrt.sv
// Two-lane pipelined floor square root of f and g scaled by 2^30.
`timescale 1ns / 1ps
`default_nettype none

module hvd_isqrt (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hvd_pkg::hav_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output hvd_pkg::root_t     out_data
);

  localparam int N  = hvd_pkg::SQRT_STEPS;
  localparam int RW = hvd_pkg::REM_W;
  localparam int QW = hvd_pkg::Q30_W;

  logic [N-1:0] v_r;
  logic         en;

  assign en        = !v_r[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  logic [RW-1:0] rem_r  [N][2];
  logic [QW-1:0] root_r [N][2];
  logic          zero_r [N];
  logic [RW-1:0] rem_in [N][2];
  logic [QW-1:0] root_in [N][2];

  // One root bit per stage, most significant first.
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int B = N - 1 - j;
    if (j == 0) begin : g_first
      assign rem_in[j][0]  = RW'(in_data.f) << 30;
      assign rem_in[j][1]  = RW'(in_data.g) << 30;
      assign root_in[j][0] = '0;
      assign root_in[j][1] = '0;
    end else begin : g_next
      assign rem_in[j][0]  = rem_r[j-1][0];
      assign rem_in[j][1]  = rem_r[j-1][1];
      assign root_in[j][0] = root_r[j-1][0];
      assign root_in[j][1] = root_r[j-1][1];
    end

    logic [RW-1:0] cand [2];
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        cand[l] = (RW'(root_in[j][l]) << (B + 1)) | (RW'(1) << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          if (rem_in[j][l] >= cand[l]) begin
            rem_r[j][l]  <= rem_in[j][l] - cand[l];
            root_r[j][l] <= root_in[j][l] | (QW'(1) << B);
          end else begin
            rem_r[j][l]  <= rem_in[j][l];
            root_r[j][l] <= root_in[j][l];
          end
        end
        zero_r[j] <= (j == 0) ? in_data.zero : zero_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign out_data.sq   = root_r[N-1][0];
  assign out_data.cq   = root_r[N-1][1];
  assign out_data.zero = zero_r[N-1];

endmodule

`default_nettype wire

>>> hw/rtl/hvd_arc.sv
// CORDIC arc tangent in vectoring mode, then scaling by the diameter.
`timescale 1ns / 1ps
`default_nettype none

module hvd_arc #(
  parameter int TRIG_ITERATIONS = hvd_pkg::TRIG_ITER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [hvd_pkg::RAD_W-1:0]   radius,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire hvd_pkg::root_t              in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [hvd_pkg::DIST_W-1:0]       out_distance
);

  localparam int NI = TRIG_ITERATIONS + 1;
  localparam int N  = NI + 2;
  localparam int XW = hvd_pkg::XY_W;
  localparam int ZW = hvd_pkg::Z_W;
  localparam int PW = hvd_pkg::ANG_W + hvd_pkg::RAD_W + 1;

  logic [N-1:0] v_r;
  logic         en;

  assign en        = !v_r[N-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[N-2:0], in_valid};
    end
  end

  logic signed [XW-1:0] x_r [NI];
  logic signed [XW-1:0] y_r [NI];
  logic signed [ZW-1:0] z_r [NI];
  logic                 zero_r [NI];

  // Load stage.
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= XW'(in_data.cq);
      y_r[0]    <= XW'(in_data.sq);
      z_r[0]    <= '0;
      zero_r[0] <= in_data.zero;
    end
  end

  // One vectoring step per stage, driving y toward zero.
  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    localparam int K = i % 32;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> K);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> K);
          z_r[i+1] <= z_r[i] + hvd_pkg::atan_q30(5'(K));
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> K);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> K);
          z_r[i+1] <= z_r[i] - hvd_pkg::atan_q30(5'(K));
        end
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // Coincident points and negative angles give zero.
  hvd_pkg::ang_t ang;
  assign ang = (zero_r[NI-1] || z_r[NI-1][ZW-1]) ? '0 : z_r[NI-1][hvd_pkg::ANG_W-1:0];

  logic [PW-1:0] prod_r;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= (PW'(ang) * PW'(radius)) << 1;
    end
  end

  // Round to Q16.16 and saturate.
  logic [PW-1:0]               d_full;
  logic [hvd_pkg::DIST_W-1:0] dist_r;
  assign d_full = (prod_r + (PW'(1) << 13)) >> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (d_full[PW-1:hvd_pkg::DIST_W] != '0) ? '1 : d_full[hvd_pkg::DIST_W-1:0];
    end
  end

  assign out_distance = dist_r;

endmodule

`default_nettype wire

>>> hw/rtl/haversine_distance_top.sv
// Top level of the haversine great-circle distance pipeline.
// One target point enters per clock and one distance leaves per clock while
// nothing stalls. The pipeline is made up of three preparation stages, two
// CORDIC chains of TRIG_ITERATIONS + 1 stages each, four product stages, a
// 31-stage square root and two scaling stages. Each module stalls as a whole
// when its last stage holds an item the next one cannot take. Core point and
// radius are written through the configuration channel, which is always
// ready, and are to be changed only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module haversine_distance_top #(
  parameter int TRIG_ITERATIONS = hvd_pkg::TRIG_ITER_DEF,
  parameter int ANGLE_FRAC_BITS = hvd_pkg::ANGLE_FRAC_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hvd_in_if.sink    in_ch,
  hvd_out_if.source out_ch,
  hvd_cfg_if.sink   cfg_ch
);

  // Configuration registers.
  logic signed [hvd_pkg::LAT_W-1:0] core_lat_r;
  logic signed [hvd_pkg::LON_W-1:0] core_lon_r;
  logic [hvd_pkg::RAD_W-1:0]        radius_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_lat_r <= '0;
      core_lon_r <= '0;
      radius_r   <= hvd_pkg::RADIUS_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        hvd_pkg::REG_CORE_LAT: core_lat_r <= cfg_ch.data[hvd_pkg::LAT_W-1:0];
        hvd_pkg::REG_CORE_LON: core_lon_r <= cfg_ch.data[hvd_pkg::LON_W-1:0];
        hvd_pkg::REG_RADIUS:   radius_r   <= cfg_ch.data[hvd_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  logic prep_v, prep_r, rot_v, rot_r, hav_v, hav_r, sq_v, sq_r;
  hvd_pkg::ang4_t  prep_d;
  hvd_pkg::trig4_t rot_d;
  hvd_pkg::hav_t   hav_d;
  hvd_pkg::root_t  sq_d;

  hvd_prep #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .core_lat  (core_lat_r),
    .core_lon  (core_lon_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_lat    (in_ch.target_lat),
    .in_lon    (in_ch.target_lon),
    .out_valid (prep_v),
    .out_ready (prep_r),
    .out_data  (prep_d)
  );

  hvd_rot #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prep_v),
    .in_ready  (prep_r),
    .in_data   (prep_d),
    .out_valid (rot_v),
    .out_ready (rot_r),
    .out_data  (rot_d)
  );

  hvd_hav u_hav (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rot_v),
    .in_ready  (rot_r),
    .in_data   (rot_d),
    .out_valid (hav_v),
    .out_ready (hav_r),
    .out_data  (hav_d)
  );

  hvd_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hav_v),
    .in_ready  (hav_r),
    .in_data   (hav_d),
    .out_valid (sq_v),
    .out_ready (sq_r),
    .out_data  (sq_d)
  );

  hvd_arc #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_arc (
    .clk          (clk),
    .rst_n        (rst_n),
    .radius       (radius_r),
    .in_valid     (sq_v),
    .in_ready     (sq_r),
    .in_data      (sq_d),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_distance (out_ch.distance)
  );

`ifndef NO_ASSERTIONS
  // Reset restores the default radius.
  a_radius_reset: assert property (@(posedge clk)
    !rst_n |=> radius_r == hvd_pkg::RADIUS_RESET)
    else $error("radius not restored by reset");

  // A core latitude write lands in the register.
  a_lat_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready && cfg_ch.index == hvd_pkg::REG_CORE_LAT)
    |=> core_lat_r == $past(cfg_ch.data[hvd_pkg::LAT_W-1:0]))
    else $error("core latitude write lost");

  // With the result side ready the whole pipeline moves and takes items.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output ready");
`endif

endmodule

`default_nettype wire
